// ===== hw/rtl/aes128_block_cipher_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef AES128_BLOCK_CIPHER_CORE_ASSERT_SVH
`define AES128_BLOCK_CIPHER_CORE_ASSERT_SVH

// Implication that must hold in the same cycle.
`define AES_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication that must hold in the following cycle.
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/aes128_pkg.sv =====
`default_nettype none
package aes128_pkg;

    localparam int NumRounds = 10;
    localparam int NumKeys   = NumRounds + 1;

    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    localparam logic REQ_ENCRYPT = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;

    typedef logic [255:0][7:0] sbox_tab_t;
    typedef logic [NumKeys-1:0][127:0] sched_keys_t;

    function automatic logic [7:0] gf_dbl(input logic [7:0] a);
        gf_dbl = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] x;
        r = 8'h00;
        x = a;
        for (int n = 0; n < 8; n++)
        begin
            if (b[n])
            begin
                r = r ^ x;
            end
            x = gf_dbl(x);
        end
        gf_mul = r;
    endfunction

    // Multiplicative inverse as a^254, with zero mapping to zero.
    function automatic logic [7:0] gf_inv(input logic [7:0] a);
        logic [7:0] r;
        logic [7:0] base;
        logic [7:0] e;
        r = 8'h01;
        base = a;
        e = 8'd254;
        for (int n = 0; n < 8; n++)
        begin
            if (e[n])
            begin
                r = gf_mul(r, base);
            end
            base = gf_mul(base, base);
        end
        gf_inv = r;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
        rotl8 = (x << n) | (x >> (8 - n));
    endfunction

    function automatic sbox_tab_t build_sbox();
        sbox_tab_t t;
        logic [7:0] b;
        for (int i = 0; i < 256; i++)
        begin
            b = gf_inv(i[7:0]);
            t[i] = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
        end
        build_sbox = t;
    endfunction

    function automatic sbox_tab_t build_inv_sbox();
        sbox_tab_t t;
        logic [7:0] b;
        for (int i = 0; i < 256; i++)
        begin
            b = rotl8(i[7:0], 1) ^ rotl8(i[7:0], 3) ^ rotl8(i[7:0], 6) ^ 8'h05;
            t[i] = gf_inv(b);
        end
        build_inv_sbox = t;
    endfunction

    localparam sbox_tab_t SBOX     = build_sbox();
    localparam sbox_tab_t INV_SBOX = build_inv_sbox();

    function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
        get_byte = s[127 - 8 * i -: 8];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/aes128_key_expand.sv =====
`default_nettype none
module aes128_key_expand (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_index,
    input  wire logic [63:0]               cfg_data,
    output logic                           keys_ready,
    output aes128_pkg::sched_keys_t        sched_keys
);
    import aes128_pkg::*;

    logic [63:0]  key_high_reg;
    logic [63:0]  key_low_reg;
    logic [3:0]   cnt_reg;
    logic         busy_reg;
    logic [7:0]   rc_reg;
    logic [127:0] prev_reg;
    sched_keys_t  rk_reg;
    logic [127:0] step_key;
    logic [31:0]  t_word;
    logic [31:0]  w0;
    logic [31:0]  w1;
    logic [31:0]  w2;
    logic [31:0]  w3;

    // One expansion step per cycle from the previous round key, while busy and no key write arrives.
    always_comb
    begin
        t_word = sub_word({prev_reg[23:0], prev_reg[31:24]}) ^ {rc_reg, 24'h0};
        w0 = prev_reg[127:96] ^ t_word;
        w1 = prev_reg[95:64] ^ w0;
        w2 = prev_reg[63:32] ^ w1;
        w3 = prev_reg[31:0] ^ w2;
        step_key = {w0, w1, w2, w3};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= 64'h0;
            key_low_reg  <= 64'h0;
            cnt_reg      <= 4'd0;
            busy_reg     <= 1'b1;
            rc_reg       <= 8'h01;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_KEY_HIGH)
            begin
                key_high_reg <= cfg_data;
            end
            else
            begin
                key_low_reg <= cfg_data;
            end
            cnt_reg  <= 4'd0;
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 4'd0)
            begin
                rc_reg <= 8'h01;
            end
            else
            begin
                rc_reg <= gf_dbl(rc_reg);
            end
            if (cnt_reg == 4'(NumRounds))
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !cfg_we)
        begin
            if (cnt_reg == 4'd0)
            begin
                rk_reg[0] <= {key_high_reg, key_low_reg};
                prev_reg  <= {key_high_reg, key_low_reg};
            end
            else
            begin
                rk_reg[cnt_reg] <= step_key;
                prev_reg        <= step_key;
            end
        end
    end

    assign keys_ready = !busy_reg;
    assign sched_keys = rk_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/aes128_round.sv =====
`default_nettype none
module aes128_round (
    input  wire logic [127:0] state_in,
    input  wire logic         decrypt,
    input  wire logic         skip_mix,
    input  wire logic [127:0] stage_key,
    output logic [127:0]      state_out
);
    import aes128_pkg::*;

    logic [7:0]   sh [16];
    logic [7:0]   ish [16];
    logic [127:0] enc_sub;
    logic [127:0] enc_mix;
    logic [127:0] dec_add;
    logic [127:0] dec_mix;
    logic [7:0]   a0;
    logic [7:0]   a1;
    logic [7:0]   a2;
    logic [7:0]   a3;
    logic [7:0]   x2 [4];
    logic [7:0]   x4 [4];
    logic [7:0]   x8 [4];
    logic [7:0]   m9 [4];
    logic [7:0]   mb [4];
    logic [7:0]   md [4];
    logic [7:0]   me [4];

    always_comb
    begin
        // Byte r + 4c holds row r, column c.
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                sh[r + 4 * c] = SBOX[get_byte(state_in, r + 4 * ((c + r) & 3))];
                ish[r + 4 * ((c + r) & 3)] = INV_SBOX[get_byte(state_in, r + 4 * c)];
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            enc_sub[127 - 8 * i -: 8] = sh[i];
            dec_add[127 - 8 * i -: 8] = ish[i] ^ get_byte(stage_key, i);
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = sh[4 * c];
            a1 = sh[4 * c + 1];
            a2 = sh[4 * c + 2];
            a3 = sh[4 * c + 3];
            enc_mix[127 - 32 * c -: 8] = gf_dbl(a0) ^ gf_dbl(a1) ^ a1 ^ a2 ^ a3;
            enc_mix[119 - 32 * c -: 8] = a0 ^ gf_dbl(a1) ^ gf_dbl(a2) ^ a2 ^ a3;
            enc_mix[111 - 32 * c -: 8] = a0 ^ a1 ^ gf_dbl(a2) ^ gf_dbl(a3) ^ a3;
            enc_mix[103 - 32 * c -: 8] = gf_dbl(a0) ^ a0 ^ a1 ^ a2 ^ gf_dbl(a3);
            for (int k = 0; k < 4; k++)
            begin
                x2[k] = gf_dbl(get_byte(dec_add, 4 * c + k));
                x4[k] = gf_dbl(x2[k]);
                x8[k] = gf_dbl(x4[k]);
                m9[k] = x8[k] ^ get_byte(dec_add, 4 * c + k);
                mb[k] = m9[k] ^ x2[k];
                md[k] = m9[k] ^ x4[k];
                me[k] = x8[k] ^ x4[k] ^ x2[k];
            end
            dec_mix[127 - 32 * c -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
            dec_mix[119 - 32 * c -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
            dec_mix[111 - 32 * c -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
            dec_mix[103 - 32 * c -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
        end
        if (decrypt)
        begin
            state_out = skip_mix ? dec_add : dec_mix;
        end
        else
        begin
            state_out = (skip_mix ? enc_sub : enc_mix) ^ stage_key;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/aes128_block_cipher_core.sv =====
// AES-128 block cipher core, encrypt and decrypt, fully unrolled pipeline.
// Input channel: in_valid/in_ready carry one item: req_type (0 encrypt,
// 1 decrypt) and a 128-bit block split into block_high and block_low, with
// byte 0 in the top bits of block_high. Output channel: out_valid/out_ready
// carry result_high and result_low in the same byte order.
// The key is written through cfg_we, cfg_index (0 key_high, 1 key_low) and
// cfg_data while the core is idle, a rule for the user that the block does not
// enforce. Round keys are expanded one per cycle in the key schedule unit, so
// in_ready stays low after reset and after every key write until all are stored.
// There are 11 stages: one for the initial AddRoundKey and one per round.
// out_valid is the valid bit of the last stage, so a result is offered once its
// item has passed every stage. Throughput is one item per cycle while out_ready
// stays high, since every stage holds a different item and hands it on each cycle.
// A stage holds its item while the next stage is full and held, so a stalled
// receiver fills the bubbles first; save during key expansion, in_ready drops only
// once the pipeline is full. Reset clears all valid bits and the key to zero.
`default_nettype none
module aes128_block_cipher_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        req_type,
    input  wire logic [63:0] block_high,
    input  wire logic [63:0] block_low,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      result_high,
    output logic [63:0]      result_low,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data
);
    import aes128_pkg::*;

    logic                         keys_ready;
    sched_keys_t                  sched_keys;
    logic [NumKeys-1:0]           v_reg;
    logic [NumKeys-2:0]           dec_reg;
    logic [NumKeys-1:0][127:0]    st_reg;
    logic [NumKeys-1:0]           stage_ready;
    logic [NumKeys-1:1][127:0]    round_out;
    logic [127:0]                 first_key;

    aes128_key_expand u_keys (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .keys_ready (keys_ready),
        .sched_keys (sched_keys)
    );

    // A stage takes a new item when it is empty or its item moves on.
    always_comb
    begin
        stage_ready[NumKeys-1] = !v_reg[NumKeys-1] || out_ready;
        for (int i = NumKeys - 2; i >= 0; i--)
        begin
            stage_ready[i] = !v_reg[i] || stage_ready[i + 1];
        end
    end

    assign in_ready  = stage_ready[0] && keys_ready;
    assign first_key = (req_type == REQ_DECRYPT) ? sched_keys[NumRounds] : sched_keys[0];

    for (genvar r = 1; r < NumKeys; r++)
    begin : g_round
        aes128_round u_round (
            .state_in  (st_reg[r - 1]),
            .decrypt   (dec_reg[r - 1]),
            .skip_mix  (r == NumRounds),
            .stage_key (dec_reg[r - 1] ? sched_keys[NumRounds - r] : sched_keys[r]),
            .state_out (round_out[r])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (stage_ready[0])
            begin
                v_reg[0] <= in_valid && keys_ready;
            end
            for (int i = 1; i < NumKeys; i++)
            begin
                if (stage_ready[i])
                begin
                    v_reg[i] <= v_reg[i - 1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            st_reg[0]  <= {block_high, block_low} ^ first_key;
            dec_reg[0] <= req_type;
        end
        for (int i = 1; i < NumKeys; i++)
        begin
            if (stage_ready[i])
            begin
                st_reg[i] <= round_out[i];
            end
        end
        // The last stage needs no direction, its round is already done.
        for (int i = 1; i < NumKeys - 1; i++)
        begin
            if (stage_ready[i])
            begin
                dec_reg[i] <= dec_reg[i - 1];
            end
        end
    end

    assign out_valid   = v_reg[NumKeys-1];
    assign result_high = st_reg[NumKeys-1][127:64];
    assign result_low  = st_reg[NumKeys-1][63:0];
endmodule
`default_nettype wire

// ===== hw/rtl/aes128_checker.sv =====
`default_nettype none
`include "aes128_block_cipher_core_assert.svh"
module aes128_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [63:0] result_high,
    input wire logic [63:0] result_low,
    input wire logic        cfg_we
);
    logic [3:0] pending_reg;
    logic [3:0] pending_next;

    // Items accepted whose results have not been taken yet.
    always_comb
    begin
        pending_next = pending_reg + 4'(in_valid && in_ready) - 4'(out_valid && out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 4'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `AES_ASSERT_NOW(a_no_invented, clk, rst_n, out_valid, pending_reg != 4'd0)
    `AES_ASSERT_NOW(a_bounded, clk, rst_n, 1'b1, pending_reg <= 4'd11)
    `AES_ASSERT_NEXT(a_key_busy, clk, rst_n, cfg_we, !in_ready)
    `AES_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                     out_valid && $stable(result_high) && $stable(result_low))
endmodule

bind aes128_block_cipher_core aes128_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_high (result_high),
    .result_low  (result_low),
    .cfg_we      (cfg_we)
);
`default_nettype wire
